// File: hw/rtl/dtbs_pkg.sv
package dtbs_pkg;

   localparam int DATA_W = 64;
   localparam int COUNT_W = 4;
   localparam int TYPE_W = 4;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [TYPE_W-1:0] {
      ST_U8  = 4'd0,
      ST_I8  = 4'd1,
      ST_U16 = 4'd2,
      ST_I16 = 4'd3,
      ST_U32 = 4'd4,
      ST_I32 = 4'd5,
      ST_U64 = 4'd6,
      ST_I64 = 4'd7,
      ST_F16 = 4'd8,
      ST_F32 = 4'd9,
      ST_F64 = 4'd10
   } sample_kind_type;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic        sign;
      logic [10:0] expo;
      logic [51:0] mant;
      logic        is_special;
      logic        is_zero_exp;
      logic [3:0]  kind;
   } item_type;

endpackage

// File: hw/rtl/dtbs_front.sv
module dtbs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  full,
   input  logic [63:0]           req_double_bits,
   input  logic                  csr_write_enable,
   input  logic [3:0]            csr_write_data,
   output logic                  item_valid,
   input  logic                  item_ready,
   output dtbs_pkg::item_type    item
);
   import dtbs_pkg::*;

   logic [TYPE_W-1:0] kind_ff;
   logic              valid_ff;
   item_type          item_ff;
   item_type          item_in;
   logic              take;

   assign full = valid_ff && !item_ready;
   assign take = req_push && !full;

   always_comb begin
      item_in.sign        = req_double_bits[63];
      item_in.expo        = req_double_bits[62:52];
      item_in.mant        = req_double_bits[51:0];
      item_in.is_special  = req_double_bits[62:52] == 11'h7ff;
      item_in.is_zero_exp = req_double_bits[62:52] == 11'h000;
      item_in.kind        = kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) kind_ff <= csr_write_data;
         if (take) valid_ff <= 1'b1;
         else if (item_ready) valid_ff <= 1'b0;
      end
      if (take) item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item = item_ff;
endmodule

// File: hw/rtl/dtbs_queue.sv
module dtbs_queue #(
   parameter int DEPTH = dtbs_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  dtbs_pkg::item_type    in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output dtbs_pkg::item_type    out_item
);
   import dtbs_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     cnt_ff;
   logic            wr, rd;

   assign in_ready  = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   assign out_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (rd) rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
      end
      if (wr) mem_ff[wr_ff] <= in_item;
   end

   property no_overflow;
      @(posedge clock) disable iff (reset) cnt_ff <= (AW+1)'(DEPTH);
   endproperty
   assert property (no_overflow) else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (rd && !wr) |=> cnt_ff == $past(cnt_ff) - 1'b1) else $error("queue drain count");
   assert property (@(posedge clock) disable iff (reset)
      (wr && !rd) |=> out_valid) else $error("queue lost item");
endmodule

// File: hw/rtl/dtbs_back.sv
module dtbs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  dtbs_pkg::item_type    item,
   output logic                  empty,
   input  logic                  rsp_pop,
   output logic [63:0]           rsp_sample_bits,
   output logic [3:0]            rsp_byte_count
);
   import dtbs_pkg::*;

   logic        valid_ff;
   logic [63:0] bits_ff, bits_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        take;

   logic [52:0] sig;
   logic [63:0] mag_r, mag_t, mag;
   logic [11:0] e;
   logic [6:0]  sh;
   logic [116:0] wide;
   logic [31:0] f32;
   logic [15:0] f16;
   logic signed [33:0] sval;
   logic signed [33:0] lo, hi;

   assign item_ready = !valid_ff || rsp_pop;
   assign take = item_valid && item_ready;

   // magnitude with value exponent e-1023, via a 117-bit shifted window
   always_comb begin
      e   = {1'b0, item.expo};
      sig = {1'b1, item.mant};
      // wide holds sig << (e-1022) with 53 fraction bits below bit 53 (for e in 1022..1086)
      wide = '0;
      mag_r = '0;
      mag_t = '0;
      sh = '0;
      if (e >= 12'd1022 && e < 12'd1087) begin
         sh = 7'(e - 12'd1022);
         wide = {64'd0, sig} << sh;
         // wide is sig*2^(e-1022); integer part = wide[116:53], half bit = wide[52]
         mag_t = wide[116:53];
         mag_r = wide[116:53] + 64'(wide[52]);
      end
   end

   // binary32 with round to nearest even
   logic [7:0]  f32e;
   logic [22:0] f32m;
   logic signed [12:0] fe;
   logic [54:0] sub_sig;
   logic [5:0]  ssh;
   logic [23:0] q;
   logic        rbit, sticky;
   logic [31:0] rq;
   always_comb begin
      fe = 13'(e) - 13'sd896;
      f32 = {item.sign, 31'd0};
      q = '0; rbit = 1'b0; sticky = 1'b0; rq = '0; ssh = '0; sub_sig = '0;
      f32e = '0; f32m = '0;
      if (item.is_special) begin
         f32 = (item.mant != 0) ? {item.sign, 8'hff, 1'b1, item.mant[50:29]}
                                : {item.sign, 8'hff, 23'd0};
      end else if (item.is_zero_exp) begin
         f32 = {item.sign, 31'd0};
      end else if (fe >= 13'sd255) begin
         f32 = {item.sign, 8'hff, 23'd0};
      end else if (fe >= 13'sd1) begin
         rq = {1'b0, fe[7:0], item.mant[51:29]};
         rbit = item.mant[28];
         sticky = item.mant[27:0] != 0;
         if (rbit && (sticky || rq[0])) rq = rq + 1'b1;
         f32 = {item.sign, rq[30:0]};
      end else if (fe >= -13'sd24) begin
         ssh = 6'(13'sd30 - fe);
         sub_sig = {2'b0, sig} >> (ssh - 6'd1);
         q = 24'(sub_sig >> 1);
         rbit = sub_sig[0];
         sticky = ({2'b0, sig} & ((55'd1 << (ssh - 6'd1)) - 55'd1)) != 0;
         if (rbit && (sticky || q[0])) q = q + 1'b1;
         f32 = {item.sign, 7'd0, q};
      end
      f32e = f32[30:23];
      f32m = f32[22:0];
   end

   logic signed [8:0] hx;
   logic [23:0] hm;
   always_comb begin
      hx = 9'(f32e) - 9'sd112;
      hm = '0;
      if (f32e == 8'hff)       f16 = {f32[31], (f32m != 0) ? 15'h7e00 : 15'h7c00};
      else if (f32e == 8'h00 && f32m == 0) f16 = {f32[31], 15'd0};
      else if (hx >= 9'sd31)  f16 = {f32[31], 15'h7c00};
      else if (hx <= 9'sd0) begin
         if (hx < -9'sd10) f16 = {f32[31], 15'd0};
         else begin
            hm = {1'b1, f32m} >> (4'(9'sd1 - hx));
            f16 = {f32[31], 5'd0, hm[22:13]};
         end
      end else f16 = {f32[31], hx[4:0], f32m[22:13]};
   end

   always_comb begin
      mag = (e >= 12'd1055) ? 64'h1_0000_0000 : mag_r;
      sval = item.sign ? -34'(mag[32:0]) : 34'(mag[32:0]);
      lo = '0; hi = '0;
      bits_in = '0;
      cnt_in = 4'd8;
      case (item.kind)
         ST_U8:  begin lo = 34'sd0;  hi = 34'sd255;  cnt_in = 4'd1; end
         ST_I8:  begin lo = -34'sd128; hi = 34'sd127; cnt_in = 4'd1; end
         ST_U16: begin lo = 34'sd0;  hi = 34'sd65535; cnt_in = 4'd2; end
         ST_I16: begin lo = -34'sd32768; hi = 34'sd32767; cnt_in = 4'd2; end
         ST_U32: begin lo = 34'sd0;  hi = 34'sh0_FFFF_FFFF; cnt_in = 4'd4; end
         ST_I32: begin lo = -34'sh0_8000_0000; hi = 34'sh0_7FFF_FFFF; cnt_in = 4'd4; end
         ST_F16: cnt_in = 4'd2;
         ST_F32: cnt_in = 4'd4;
         default: cnt_in = 4'd8;
      endcase
      if (sval < lo) sval = lo;
      if (sval > hi) sval = hi;
      case (item.kind)
         ST_U8, ST_I8:   bits_in = {56'd0, sval[7:0]};
         ST_U16, ST_I16: bits_in = {48'd0, sval[15:0]};
         ST_U32, ST_I32: bits_in = {32'd0, sval[31:0]};
         ST_U64: begin
            if (item.is_special || item.sign || e < 12'd1023) bits_in = '0;
            else if (e >= 12'd1087) bits_in = '1;
            else bits_in = mag_t;
         end
         ST_I64: begin
            if (item.is_special) bits_in = '0;
            else if (e >= 12'd1086) bits_in = item.sign ? 64'h8000_0000_0000_0000
                                                         : 64'h7fff_ffff_ffff_ffff;
            else if (e >= 12'd1075) bits_in = item.sign ? -mag_t : mag_t;
            else bits_in = item.sign ? -mag_r : mag_r;
         end
         ST_F16: bits_in = {48'd0, f16};
         ST_F32: bits_in = {32'd0, f32};
         ST_F64: bits_in = {item.sign, item.expo, item.mant};
         default: bits_in = '0;
      endcase
      if (item.is_special && item.kind < ST_U64) bits_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (take) valid_ff <= 1'b1;
      else if (rsp_pop) valid_ff <= 1'b0;
      if (take) begin
         bits_ff <= bits_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign empty = !valid_ff;
   assign rsp_sample_bits = bits_ff;
   assign rsp_byte_count = cnt_ff;

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_pop) |=> $stable(bits_ff) && valid_ff) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cnt_ff == 4'd1 || cnt_ff == 4'd2 || cnt_ff == 4'd4 || cnt_ff == 4'd8))
      else $error("bad byte count");
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && cnt_ff == 4'd1) |-> bits_ff[63:8] == '0) else $error("upper bits set");
endmodule

// File: hw/rtl/double_to_band_sample_convert.sv
// Converts one binary64 value per cycle, while full is low, into the sample
// type held in the csr register (u8..i64, f16, f32, f64), result little-endian
// in the low bytes with its byte count. Sustained rate is one item per cycle
// while the queue has room; the result passes through the front register, the
// queue and the back result register before it shows up on the result ports.
// The front classifies, a small queue decouples it from the back, which does
// all rounding and saturation in one registered stage.
module double_to_band_sample_convert #(
   parameter int QUEUE_DEPTH = dtbs_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        full,
   input  logic [63:0] req_double_bits,
   output logic        empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_sample_bits,
   output logic [3:0]  rsp_byte_count,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data
);
   import dtbs_pkg::*;

   item_type f_item, q_item;
   logic     f_valid, f_ready, q_valid, q_ready;

   dtbs_front u_front (
      .clock, .reset, .req_push, .full, .req_double_bits,
      .csr_write_enable, .csr_write_data,
      .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
   );

   dtbs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   dtbs_back u_back (
      .clock, .reset, .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
      .empty, .rsp_pop, .rsp_sample_bits, .rsp_byte_count
   );
endmodule

// File: bench/double_to_band_sample_convert_checker.sv
module double_to_band_sample_convert_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        full,
   input  logic [63:0] req_double_bits,
   input  logic        empty,
   input  logic        rsp_pop,
   input  logic [63:0] rsp_sample_bits,
   input  logic [3:0]  rsp_byte_count,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   output int          mismatch_count,
   output int          samples_pending
);
   import dtbs_pkg::*;

   localparam logic [63:0] SIGN_BIT = 64'h8000000000000000;
   localparam logic [63:0] MANT_MASK = 64'h000fffffffffffff;
   localparam logic [63:0] HIDDEN_BIT = 64'h0010000000000000;

   typedef struct {
      logic [63:0] bits;
      logic [3:0]  count;
   } expected_sample_type;

   expected_sample_type expected_samples[$];
   logic [3:0] kind_reg;

   assign samples_pending = expected_samples.size();

   function automatic logic [63:0] round_half_away(logic [63:0] sig, int sh);
      return (sig + (64'd1 << (sh - 1))) >> sh;
   endfunction

   function automatic logic [63:0] round_half_even(logic [63:0] sig, int sh);
      logic [63:0] q, r, half;
      q = sig >> sh;
      r = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (r > half || (r == half && q[0]))
         q = q + 64'd1;
      return q;
   endfunction

   function automatic logic [63:0] conv_small_int(logic [63:0] d, longint lo, longint hi,
                                                   logic [63:0] mask);
      int e;
      logic [63:0] mag;
      longint val;
      e = int'(d[62:52]);
      if (e == 2047)
         return 64'd0;
      if (e < 1022)
         mag = 64'd0;
      else if (e >= 1055)
         mag = 64'd1 << 32;
      else
         mag = round_half_away((d & MANT_MASK) | HIDDEN_BIT, 1075 - e);
      val = d[63] ? -$signed(mag) : $signed(mag);
      if (val < lo) val = lo;
      if (val > hi) val = hi;
      return 64'(val) & mask;
   endfunction

   function automatic logic [63:0] conv_u64(logic [63:0] d);
      int e;
      logic [63:0] sig;
      e = int'(d[62:52]);
      sig = (d & MANT_MASK) | HIDDEN_BIT;
      if (e == 2047 || d[63] || e < 1023)
         return 64'd0;
      if (e >= 1087)
         return '1;
      if (e >= 1075)
         return sig << (e - 1075);
      return sig >> (1075 - e);
   endfunction

   function automatic logic [63:0] conv_i64(logic [63:0] d);
      int e;
      logic [63:0] sig, mag;
      e = int'(d[62:52]);
      sig = (d & MANT_MASK) | HIDDEN_BIT;
      if (e == 2047)
         return 64'd0;
      if (e >= 1086)
         return d[63] ? SIGN_BIT : SIGN_BIT - 64'd1;
      if (e < 1022)
         mag = 64'd0;
      else if (e >= 1075)
         mag = sig << (e - 1075);
      else
         mag = round_half_away(sig, 1075 - e);
      return d[63] ? 64'd0 - mag : mag;
   endfunction

   function automatic logic [31:0] conv_f32(logic [63:0] d);
      logic [31:0] sign;
      int e, fe, sh;
      logic [63:0] m, r;
      sign = {d[63], 31'd0};
      e = int'(d[62:52]);
      m = d & MANT_MASK;
      if (e == 2047) begin
         if (m != 0)
            return sign | 32'h7fc00000 | 32'(m >> 29);
         return sign | 32'h7f800000;
      end
      if (e == 0)
         return sign;
      fe = e - 1023 + 127;
      if (fe >= 255)
         return sign | 32'h7f800000;
      if (fe >= 1) begin
         r = round_half_even((64'(fe) << 52) | m, 29);
         return sign | r[31:0];
      end
      sh = 30 - fe;
      if (sh > 54)
         return sign;
      r = round_half_even(m | HIDDEN_BIT, sh);
      return sign | r[31:0];
   endfunction

   function automatic logic [15:0] narrow_f16(logic [31:0] x);
      logic [15:0] sign;
      logic [31:0] mant;
      int ex;
      sign = {x[31], 15'd0};
      mant = x & 32'h007fffff;
      ex = int'(x[30:23]);
      if (ex == 255)
         return sign | (mant != 0 ? 16'h7e00 : 16'h7c00);
      if (ex == 0 && mant == 0)
         return sign;
      ex = ex - 127 + 15;
      if (ex >= 31)
         return sign | 16'h7c00;
      if (ex <= 0) begin
         if (ex < -10)
            return sign;
         mant = (mant | 32'h00800000) >> (1 - ex);
         return sign | 16'(mant >> 13);
      end
      return sign | 16'(ex << 10) | 16'(mant >> 13);
   endfunction

   function automatic expected_sample_type convert_sample(logic [3:0] kind, logic [63:0] d);
      expected_sample_type s;
      s.bits = 64'd0;
      s.count = 4'd8;
      case (kind)
         ST_U8: begin s.bits = conv_small_int(d, 0, 255, 64'hff); s.count = 4'd1; end
         ST_I8: begin s.bits = conv_small_int(d, -128, 127, 64'hff); s.count = 4'd1; end
         ST_U16: begin s.bits = conv_small_int(d, 0, 65535, 64'hffff); s.count = 4'd2; end
         ST_I16: begin s.bits = conv_small_int(d, -32768, 32767, 64'hffff); s.count = 4'd2; end
         ST_U32: begin
            s.bits = conv_small_int(d, 0, 64'd4294967295, 64'hffffffff);
            s.count = 4'd4;
         end
         ST_I32: begin
            s.bits = conv_small_int(d, -64'sd2147483648, 64'sd2147483647, 64'hffffffff);
            s.count = 4'd4;
         end
         ST_U64: s.bits = conv_u64(d);
         ST_I64: s.bits = conv_i64(d);
         ST_F16: begin s.bits = 64'(narrow_f16(conv_f32(d))); s.count = 4'd2; end
         ST_F32: begin s.bits = 64'(conv_f32(d)); s.count = 4'd4; end
         ST_F64: s.bits = d;
         default: ;
      endcase
      return s;
   endfunction

   always @(posedge clock) begin
      expected_sample_type want;
      if (reset) begin
         kind_reg <= 4'd0;
         expected_samples.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_write_enable)
            kind_reg <= csr_write_data;
         if (req_push && !full)
            expected_samples.insert(expected_samples.size(),
                                    convert_sample(kind_reg, req_double_bits));
         if (rsp_pop && !empty) begin
            if (expected_samples.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected sample %h count %0d", rsp_sample_bits, rsp_byte_count);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_samples.pop_front();
               if (want.bits !== rsp_sample_bits || want.count !== rsp_byte_count) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected %h/%0d got %h/%0d", want.bits, want.count,
                              rsp_sample_bits, rsp_byte_count);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: bench/double_to_band_sample_convert_tb.sv
module double_to_band_sample_convert_tb;
   import dtbs_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        full;
   logic [63:0] req_double_bits = 64'd0;
   logic        empty;
   logic        rsp_pop = 1'b0;
   logic [63:0] rsp_sample_bits;
   logic [3:0]  rsp_byte_count;
   logic        csr_write_enable = 1'b0;
   logic [3:0]  csr_write_data = 4'd0;
   int          mismatch_count;
   int          samples_pending;

   logic [63:0] corner_values[18] = '{
      64'h0000000000000000, 64'h8000000000000000, 64'h3ff0000000000000,
      64'hbff0000000000000, 64'h3fe0000000000000, 64'hbfe0000000000000,
      64'h4004000000000000, 64'h406ff00000000000, 64'h7ff0000000000000,
      64'hfff0000000000000, 64'h7ff8000000000000, 64'hfff0000000000001,
      64'h0000000000000001, 64'h43e0000000000000, 64'h43f0000000000000,
      64'hc3e0000000000000, 64'h7fefffffffffffff, 64'h3f10000000000000
   };
   // codes 11 to 15 have no sample type
   logic [3:0] phase_kinds[19] = '{
      ST_U8, ST_I8, ST_U16, ST_I16, ST_U32, ST_I32, ST_U64, ST_I64, ST_F16, ST_F32,
      ST_F64, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15, ST_F64, ST_U8, ST_F16
   };

   always #4 clock = ~clock;

   double_to_band_sample_convert i_dut (
      .clock(clock), .reset(reset), .req_push(req_push), .full(full),
      .req_double_bits(req_double_bits), .empty(empty), .rsp_pop(rsp_pop),
      .rsp_sample_bits(rsp_sample_bits), .rsp_byte_count(rsp_byte_count),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   double_to_band_sample_convert_checker i_checker (
      .clock(clock), .reset(reset), .req_push(req_push), .full(full),
      .req_double_bits(req_double_bits), .empty(empty), .rsp_pop(rsp_pop),
      .rsp_sample_bits(rsp_sample_bits), .rsp_byte_count(rsp_byte_count),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count), .samples_pending(samples_pending)
   );

   function automatic int pick_gap();
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(10, 80);
      if ($urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [63:0] random_double();
      logic [63:0] d;
      case ($urandom_range(0, 5))
         0: d = {$urandom, $urandom};
         1: d = {1'($urandom), 11'($urandom_range(1000, 1090)), 20'($urandom), $urandom};
         2: d = {1'($urandom), ($urandom_range(0, 1) ? 11'h7ff : 11'h000),
                 20'($urandom), $urandom};
         3: d = {1'($urandom), 11'($urandom_range(860, 1060)), 20'($urandom), $urandom};
         4: begin
            d = $realtobits(real'($urandom_range(0, 1 << 20)) + 0.5);
            d[63] = 1'($urandom);
         end
         default: d = {1'($urandom), 11'($urandom_range(1020, 1090)),
                       4'($urandom), 48'd0};
      endcase
      return d;
   endfunction

   task automatic push_double(logic [63:0] d);
      int gap;
      gap = pick_gap();
      repeat (gap) @(negedge clock) req_push <= 1'b0;
      @(negedge clock);
      req_push <= 1'b1;
      req_double_bits <= d;
      do @(posedge clock); while (full);
   endtask

   task automatic drain_outputs();
      @(negedge clock) req_push <= 1'b0;
      while (samples_pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // Receiver: hold off long at the start so the input backs up, then pop with gaps.
   initial begin
      int gap;
      gap = 0;
      wait (!reset);
      repeat (300) @(negedge clock) rsp_pop <= 1'b0;
      forever begin
         @(negedge clock);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            gap--;
         end else begin
            rsp_pop <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               gap = pick_gap();
         end
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !full) || (rsp_pop && !empty) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      foreach (phase_kinds[p]) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data <= phase_kinds[p];
         @(negedge clock) csr_write_enable <= 1'b0;
         foreach (corner_values[i])
            push_double(corner_values[i]);
         repeat (24)
            push_double(random_double());
         drain_outputs();
      end
      if (mismatch_count == 0 && samples_pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: double_to_band_sample_convert.f
hw/rtl/dtbs_pkg.sv
hw/rtl/dtbs_front.sv
hw/rtl/dtbs_queue.sv
hw/rtl/dtbs_back.sv
hw/rtl/double_to_band_sample_convert.sv
bench/double_to_band_sample_convert_checker.sv
bench/double_to_band_sample_convert_tb.sv
